FILE: design/zipc_pkg.sv
// shared types, constants and crc step for the zip traditional stream cipher
`timescale 1ns / 1ps

package zipc_pkg;

    localparam logic [31:0] KEY0_INIT  = 32'h1234_5678;
    localparam logic [31:0] KEY1_INIT  = 32'h2345_6789;
    localparam logic [31:0] KEY2_INIT  = 32'h3456_7890;
    localparam logic [31:0] KEY1_MULT  = 32'd134775813;
    localparam logic [31:0] LOW24_MASK = 32'h00FF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

    localparam int REQ_W  = 2;
    localparam int BYTE_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_RESTART = 2'd0,
        REQ_ABSORB  = 2'd1,
        REQ_ENCRYPT = 2'd2
    } req_type_t;

    typedef struct packed {
        logic [31:0] key_zero;
        logic [31:0] key_one;
        logic [31:0] key_two;
    } key_set_t;

    localparam key_set_t KEYS_INIT = '{key_zero: KEY0_INIT, key_one: KEY1_INIT,
                                       key_two: KEY2_INIT};

    // reflected crc-32 byte step, no inversion
    function automatic logic [31:0] crc_byte_step(input logic [31:0] acc,
                                                  input logic [7:0]  b);
        logic [31:0] t;
        t = {24'd0, acc[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
            if (t[0]) begin
                t = (t >> 1) ^ CRC_POLY;
            end else begin
                t = t >> 1;
            end
        end
        return ((acc >> 8) & LOW24_MASK) ^ t;
    endfunction

endpackage

FILE: design/zipc_key_update.sv
// key update: crc step on key zero, multiply-add on key one, crc step on key two
`timescale 1ns / 1ps

module zipc_key_update (
    input  zipc_pkg::key_set_t  keys_in,
    input  logic [7:0]          data_byte,
    output zipc_pkg::key_set_t  keys_out
);
    import zipc_pkg::*;

    logic [31:0] k0_new;
    logic [31:0] k1_sum;
    logic [31:0] k1_new;

    always_comb begin
        k0_new = crc_byte_step(keys_in.key_zero, data_byte);
        k1_sum = keys_in.key_one + {24'd0, k0_new[7:0]};
        k1_new = k1_sum * KEY1_MULT + 32'd1;
        keys_out.key_zero = k0_new;
        keys_out.key_one  = k1_new;
        keys_out.key_two  = crc_byte_step(keys_in.key_two, k1_new[31:24]);
    end

endmodule

FILE: design/zipc_keystream.sv
// keystream byte from the low half of key two
`timescale 1ns / 1ps

module zipc_keystream (
    input  logic [31:0] key_two,
    output logic [7:0]  ks_byte
);
    import zipc_pkg::*;

    logic [15:0] t;
    logic [15:0] prod;

    always_comb begin
        t       = key_two[15:0] | 16'd2;
        prod    = t * (t ^ 16'd1);
        ks_byte = prod[15:8];
    end

endmodule

FILE: design/zip_traditional_stream_cipher_core.sv
// top level: request register, key state, keystream and result register
// a request goes through the request register, then the result register drives m_tvalid
// one request per cycle unless m_tready stalls; key update and keystream are combinational
// restart, password and unused requests give no result
// reset: aresetn low clears both stages and loads the three starting keys
`timescale 1ns / 1ps

module zip_traditional_stream_cipher_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] cipher_byte
);
    import zipc_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [REQ_W-1:0]  in_req_reg, in_req_next;
    logic [BYTE_W-1:0] in_data_reg, in_data_next;
    key_set_t          keys_reg, keys_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;

    key_set_t          keys_upd;
    logic [7:0]        ks_byte;
    logic              advance;
    logic              fire;

    zipc_key_update u_key_update (
        .keys_in   (keys_reg),
        .data_byte (in_data_reg),
        .keys_out  (keys_upd)
    );

    zipc_keystream u_keystream (
        .key_two (keys_reg.key_two),
        .ks_byte (ks_byte)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_req_next    = in_req_reg;
        in_data_next   = in_data_reg;
        keys_next      = keys_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_req_next   = s_tuser;
            in_data_next  = s_tdata;
        end

        if (advance) begin
            out_valid_next = 1'b0;
        end

        if (fire) begin
            case (in_req_reg)
                REQ_RESTART: begin
                    keys_next = KEYS_INIT;
                end
                REQ_ABSORB: begin
                    keys_next = keys_upd;
                end
                REQ_ENCRYPT: begin
                    keys_next      = keys_upd;
                    out_valid_next = 1'b1;
                    out_data_next  = in_data_reg ^ ks_byte;
                end
                default: begin
                    keys_next = keys_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            keys_reg      <= KEYS_INIT;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            keys_reg      <= keys_next;
        end
        in_req_reg   <= in_req_next;
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    // restart request loads the starting keys
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_req_reg == REQ_RESTART) |=> (keys_reg == KEYS_INIT))
        else $error("keys not restarted");

    // only encrypt requests give a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_req_reg != REQ_ENCRYPT) |=> !m_tvalid)
        else $error("result from a non-encrypt request");

    // unused request type leaves the keys alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_req_reg != REQ_RESTART && in_req_reg != REQ_ABSORB
              && in_req_reg != REQ_ENCRYPT) |=> $stable(keys_reg))
        else $error("keys changed by unused request");

    // keys change only when a request is processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(keys_reg))
        else $error("keys changed without a request");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the zip traditional stream cipher core
`timescale 1ns / 1ps

module testbench;
    import zipc_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT  = 500;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         ITEM_TARGET  = 400;
    localparam int         QUIET_AFTER  = 320;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data_byte
    logic [1:0] s_tuser;   // [1:0] req_type
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] cipher_byte

    key_set_t   cipher_keys;
    logic [7:0] expected_cipher[$];
    int         error_count = 0;
    int         request_count = 0;
    int         idle_cycles = 0;
    bit         gaps_on = 1'b1;
    bit         stalls_on = 1'b1;

    zip_traditional_stream_cipher_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [31:0] crc32_shift(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] keystream_of(input key_set_t k);
        logic [15:0] t;
        logic [31:0] p;
        t = k.key_two[15:0] | 16'd2;
        p = t * (t ^ 16'd1);
        return p[15:8];
    endfunction

    function automatic key_set_t keys_after(input key_set_t k, input logic [7:0] b);
        key_set_t n;
        n.key_zero = crc32_shift(k.key_zero, b);
        n.key_one  = (k.key_one + {24'd0, n.key_zero[7:0]}) * KEY1_MULT + 32'd1;
        n.key_two  = crc32_shift(k.key_two, n.key_one[31:24]);
        return n;
    endfunction

    // key state tracks every accepted request
    always @(posedge aclk) begin
        if (!aresetn) begin
            cipher_keys = KEYS_INIT;
        end else if (s_tvalid && s_tready) begin
            case (s_tuser)
                REQ_RESTART: cipher_keys = KEYS_INIT;
                REQ_ABSORB: cipher_keys = keys_after(cipher_keys, s_tdata);
                REQ_ENCRYPT: begin
                    expected_cipher.push_back(s_tdata ^ keystream_of(cipher_keys));
                    cipher_keys = keys_after(cipher_keys, s_tdata);
                end
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        logic [7:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cipher.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %02h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_cipher.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: cipher_byte mismatch, expected %02h, actual %02h",
                             $time, want, m_tdata);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_cipher.size());
            $display("** zip_traditional_stream_cipher_core: FAILED **");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                repeat (n) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [7:0] data);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 7);
            repeat (n) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        if (req != REQ_UNUSED) begin
            request_count++;
        end
        if (request_count >= QUIET_AFTER) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
        end
    endtask

    task automatic wait_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_cipher.size() != 0) @(posedge aclk);
    endtask

    task automatic test_starting_keys();
        send_request(REQ_ENCRYPT, 8'h00);
        send_request(REQ_ENCRYPT, 8'hFF);
        send_request(REQ_ENCRYPT, 8'h5A);
    endtask

    task automatic test_special_requests();
        send_request(REQ_RESTART, 8'hFF);
        send_request(REQ_ENCRYPT, 8'h00);
        send_request(REQ_UNUSED, 8'hFF);
        send_request(REQ_UNUSED, 8'h00);
        send_request(REQ_ENCRYPT, 8'hFF);
        send_request(REQ_ABSORB, 8'h00);
        send_request(REQ_ABSORB, 8'hFF);
        send_request(REQ_ENCRYPT, 8'hA5);
        send_request(REQ_RESTART, 8'h00);
        send_request(REQ_ENCRYPT, 8'h3C);
        send_request(REQ_ABSORB, 8'h81);
        send_request(REQ_ENCRYPT, 8'h7E);
    endtask

    task automatic encrypt_session(input int pw_len, input int body_len);
        send_request(REQ_RESTART, 8'($urandom));
        repeat (pw_len) send_request(REQ_ABSORB, 8'($urandom));
        repeat (12) send_request(REQ_ENCRYPT, 8'($urandom));
        repeat (body_len) send_request(REQ_ENCRYPT, 8'($urandom));
    endtask

    task automatic test_password_header();
        encrypt_session(8, 4);
        // sender holds off until everything is back
        wait_until_drained();
        encrypt_session(1, 0);
    endtask

    task automatic test_random_sessions();
        int n;
        while (request_count < ITEM_TARGET) begin
            if ($urandom_range(0, 4) != 0) begin
                encrypt_session($urandom_range(0, 16), $urandom_range(0, 30));
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) send_request(2'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = REQ_RESTART;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_starting_keys();
        test_special_requests();
        test_password_header();
        test_random_sessions();

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_cipher.size() == 0) begin
            $display("** zip_traditional_stream_cipher_core: PASSED **");
        end else begin
            $display("** zip_traditional_stream_cipher_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: zip_traditional_stream_cipher_core.f
design/zipc_pkg.sv
design/zipc_key_update.sv
design/zipc_keystream.sv
design/zip_traditional_stream_cipher_core.sv
dv/testbench.sv
